>>> hw/rtl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared constants and types for the block reverse buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

	localparam int MaxGroup = 16;
	localparam int ValW     = 32;
	localparam int GsW      = 5;
	localparam int CntW     = $clog2(MaxGroup + 1);
	localparam int IdxW     = $clog2(MaxGroup);

	localparam logic [GsW-1:0] GsReset = GsW'(2);

	// per-cycle control broadcast to every cell of the row
	typedef struct packed {
		logic shift_up;   // take the left neighbor's value (fill)
		logic shift_dn;   // take the right neighbor's value (reverse drain)
	} brb_cell_ctrl_t;

endpackage

>>> hw/rtl/brb_ifs.sv
// ----------------------------------------------------------------------------
// brb_ifs
// Valid/ready channels of the block reverse buffer.
// ----------------------------------------------------------------------------
interface brb_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [brb_pkg::ValW-1:0]   value;
	logic                              seq_end;

	modport source (output valid, value, seq_end, input ready);
	modport sink   (input valid, value, seq_end, output ready);
endinterface

interface brb_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [brb_pkg::ValW-1:0]   out_value;
	logic                              run_last;
	logic                              out_seq_end;

	modport source (output valid, out_value, run_last, out_seq_end, input ready);
	modport sink   (input valid, out_value, run_last, out_seq_end, output ready);
endinterface

interface brb_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [brb_pkg::GsW-1:0]     group_size;

	modport source (output valid, group_size, input ready);
	modport sink   (input valid, group_size, output ready);
endinterface

>>> hw/rtl/brb_cell.sv
// ----------------------------------------------------------------------------
// brb_cell
// One storage cell of the group row; shifts up on fill, down on drain.
// ----------------------------------------------------------------------------
module brb_cell (
	input  logic                            clk,
	input  brb_pkg::brb_cell_ctrl_t         ctrl,
	input  logic signed [brb_pkg::ValW-1:0] left,
	input  logic signed [brb_pkg::ValW-1:0] right,
	output logic signed [brb_pkg::ValW-1:0] q
);

	logic signed [brb_pkg::ValW-1:0] val_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift_up) begin
			val_q <= left;
		end else if (ctrl.shift_dn) begin
			val_q <= right;
		end
	end

	assign q = val_q;

endmodule

>>> hw/rtl/block_reverse_buffer.sv
// ----------------------------------------------------------------------------
// block_reverse_buffer
// Reverses a value stream in groups of group_size (at most MaxGroup) using a row of cells.
// ----------------------------------------------------------------------------
// With group_size 0 or 1 every value passes through at one transfer per
// cycle while the output is not stalled. Otherwise values shift into a row
// of MaxGroup cells, one per cycle; when the group is full it drains newest
// first, one result per cycle unless the output stalls, by shifting the row
// back toward cell 0. A short group closed by seq_end drains oldest first,
// read from the row by position. Input is held off while a group drains.
// The single output register lets a group keep filling while a result
// waits. Writing group_size discards any partial group; the write is taken
// only while no group drains, and holds off input in its cycle.
module block_reverse_buffer (
	input  logic            clk,
	input  logic            arst_n,
	brb_in_if.sink          sample,
	brb_cfg_if.sink         cfg,
	brb_out_if.source       result
);

	localparam logic StFill  = 1'b0;
	localparam logic StDrain = 1'b1;

	logic                                state_q;
	logic [brb_pkg::GsW-1:0]             gs_q;
	logic [brb_pkg::CntW-1:0]            fill_q;
	logic [brb_pkg::CntW-1:0]            rem_q;
	logic                                rev_q;
	logic                                end_q;

	logic                                ovalid_q;
	logic signed [brb_pkg::ValW-1:0]     oval_q;
	logic                                olast_q;
	logic                                oend_q;

	logic [brb_pkg::CntW-1:0]            eff_g;
	logic [brb_pkg::CntW-1:0]            fill_nxt;
	logic                                slot_free;
	logic                                in_xfer;
	logic                                cfg_xfer;
	logic                                pass;
	logic                                drain_step;
	logic [brb_pkg::IdxW-1:0]            rd_idx;
	logic signed [brb_pkg::ValW-1:0]     drain_val;
	brb_pkg::brb_cell_ctrl_t             ctrl;

	logic signed [brb_pkg::ValW-1:0]     cell_q [brb_pkg::MaxGroup];

	always_comb begin
		if (int'(gs_q) > brb_pkg::MaxGroup) begin
			eff_g = brb_pkg::CntW'(brb_pkg::MaxGroup);
		end else begin
			eff_g = brb_pkg::CntW'(gs_q);
		end
	end

	assign slot_free    = !ovalid_q || result.ready;
	// only a pass-through transfer needs the output slot
	assign sample.ready = (state_q == StFill) && (slot_free || !pass) && !cfg.valid;
	assign cfg.ready    = (state_q == StFill);
	assign in_xfer      = sample.valid && sample.ready;
	assign cfg_xfer     = cfg.valid && cfg.ready;
	assign pass         = (eff_g <= brb_pkg::CntW'(1));
	assign fill_nxt     = fill_q + brb_pkg::CntW'(1);
	assign drain_step   = (state_q == StDrain) && slot_free;

	assign rd_idx    = brb_pkg::IdxW'(rem_q - brb_pkg::CntW'(1));
	assign drain_val = rev_q ? cell_q[0] : cell_q[rd_idx];

	assign ctrl.shift_up = in_xfer && !pass;
	assign ctrl.shift_dn = drain_step && rev_q;

	for (genvar i = 0; i < brb_pkg::MaxGroup; i++) begin : g_cell
		logic signed [brb_pkg::ValW-1:0] left_d;
		logic signed [brb_pkg::ValW-1:0] right_d;

		if (i == 0) begin : g_head
			assign left_d = sample.value;
		end else begin : g_body
			assign left_d = cell_q[i-1];
		end
		if (i == brb_pkg::MaxGroup - 1) begin : g_tail
			assign right_d = '0;
		end else begin : g_inner
			assign right_d = cell_q[i+1];
		end

		brb_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.left  (left_d),
			.right (right_d),
			.q     (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StFill;
			gs_q    <= brb_pkg::GsReset;
			fill_q  <= '0;
			rem_q   <= '0;
			rev_q   <= 1'b0;
			end_q   <= 1'b0;
		end else begin
			if (cfg_xfer) begin
				gs_q   <= cfg.group_size;
				fill_q <= '0;
			end else if (in_xfer) begin
				if (pass) begin
					fill_q <= '0;
				end else if (fill_nxt == eff_g) begin
					state_q <= StDrain;
					rem_q   <= fill_nxt;
					rev_q   <= 1'b1;
					end_q   <= sample.seq_end;
					fill_q  <= '0;
				end else if (sample.seq_end) begin
					state_q <= StDrain;
					rem_q   <= fill_nxt;
					rev_q   <= 1'b0;
					end_q   <= 1'b1;
					fill_q  <= '0;
				end else begin
					fill_q <= fill_nxt;
				end
			end else if (drain_step) begin
				rem_q <= rem_q - brb_pkg::CntW'(1);
				if (rem_q == brb_pkg::CntW'(1)) begin
					state_q <= StFill;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (in_xfer && pass) begin
			ovalid_q <= 1'b1;
		end else if (drain_step) begin
			ovalid_q <= 1'b1;
		end else if (result.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && pass) begin
			oval_q  <= sample.value;
			olast_q <= 1'b1;
			oend_q  <= sample.seq_end;
		end else if (drain_step) begin
			oval_q  <= drain_val;
			olast_q <= (rem_q == brb_pkg::CntW'(1));
			oend_q  <= (rem_q == brb_pkg::CntW'(1)) && end_q;
		end
	end

	assign result.valid       = ovalid_q;
	assign result.out_value   = oval_q;
	assign result.run_last    = olast_q;
	assign result.out_seq_end = oend_q;

	a_drain_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == StDrain |-> rem_q != '0)
		else $error("drain with no values left");

	a_fill_below_group: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == StFill |-> fill_q == '0 || fill_q < eff_g)
		else $error("fill count reached group size");

	a_no_accept_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		sample.ready |-> state_q == StFill)
		else $error("input ready while draining");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.out_seq_end |-> result.run_last)
		else $error("sequence end on a result that is not last of its run");

	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		drain_step && rem_q == brb_pkg::CntW'(1) |=> state_q == StFill)
		else $error("drain did not return to fill");

endmodule
